// ===== sv/gbtb_pkg.sv =====
// Shared types and constants for the Gaussian box transition bounds block.
// Holds the controller/datapath command and status words and the exp helper
// used when the CDF table is built at elaboration.
package gbtb_pkg;

    localparam int EVAL_COUNT = 6;
    localparam int SEL_W      = 3;
    localparam int DIV_STEPS  = 19;
    localparam int CNT_W      = 5;

    localparam longint unsigned LN2_Q26 = 64'd46516320;

    typedef struct packed {
        logic             load;
        logic             prep;
        logic             eval_load;
        logic             div_step;
        logic             cdf_a;
        logic             cdf_b;
        logic             cdf_c;
        logic             cdf_d;
        logic             mass;
        logic             prod;
        logic [SEL_W-1:0] sel;
    } gbtb_cmd_t;

    typedef struct packed {
        logic last;
        logic out_busy;
    } gbtb_sts_t;

    // floor(num / den), restoring long division, elaboration use only
    function automatic longint unsigned div_u64(input longint unsigned num,
                                                input longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = 64'd0;
        r = 64'd0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], num[i]};
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q = q | 64'd1;
            end
        end
        return q;
    endfunction

    // exp(-x), x in Q6.26, result in Q2.30
    function automatic longint unsigned exp_neg(input longint unsigned x26);
        longint unsigned n;
        longint unsigned r30;
        longint unsigned sum;
        longint unsigned term;
        longint unsigned kk;
        n    = x26 / LN2_Q26;
        r30  = (x26 - n * LN2_Q26) << 4;
        sum  = 64'd1 << 30;
        term = 64'd1 << 30;
        if (n >= 64'd63) begin
            return 64'd0;
        end
        for (kk = 64'd1; kk <= 64'd13; kk++) begin
            term = div_u64((term * r30) >> 30, kk);
            if (kk[0]) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return sum >> n;
    endfunction

endpackage

// ===== sv/gbtb_ctrl.sv =====
// Sequencer for the transition bounds block.
// Depends on gbtb_pkg for the command and status words.
module gbtb_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  gbtb_pkg::gbtb_sts_t sts,
    output gbtb_pkg::gbtb_cmd_t cmd
);
    import gbtb_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_PREP = 4'd1;
    localparam logic [3:0] ST_LOAD = 4'd2;
    localparam logic [3:0] ST_DIV  = 4'd3;
    localparam logic [3:0] ST_CA   = 4'd4;
    localparam logic [3:0] ST_CB   = 4'd5;
    localparam logic [3:0] ST_CC   = 4'd6;
    localparam logic [3:0] ST_CD   = 4'd7;
    localparam logic [3:0] ST_MASS = 4'd8;
    localparam logic [3:0] ST_PROD = 4'd9;

    logic [3:0]       state_reg, state_next;
    logic [SEL_W-1:0] sel_reg, sel_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sel_reg   <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        sel_next   = sel_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.sel    = sel_reg;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = aresetn;
                cmd.load = s_valid && aresetn;
                if (s_valid) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                sel_next   = '0;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                cmd.eval_load = 1'b1;
                cnt_next      = '0;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_CA;
                end
            end
            ST_CA: begin
                cmd.cdf_a  = 1'b1;
                state_next = ST_CB;
            end
            ST_CB: begin
                cmd.cdf_b  = 1'b1;
                state_next = ST_CC;
            end
            ST_CC: begin
                cmd.cdf_c  = 1'b1;
                state_next = ST_CD;
            end
            ST_CD: begin
                cmd.cdf_d = 1'b1;
                if (sel_reg == SEL_W'(EVAL_COUNT - 1)) begin
                    state_next = ST_MASS;
                end else begin
                    sel_next   = sel_reg + 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_MASS: begin
                cmd.mass   = 1'b1;
                state_next = ST_PROD;
            end
            ST_PROD: begin
                if (!(sts.last && sts.out_busy)) begin
                    cmd.prod   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/gbtb_datapath.sv =====
// Datapath: operand registers, shared z divider, CDF table interpolator,
// bound clamping and running products with the result word register.
// Depends on gbtb_pkg.
module gbtb_datapath #(
    parameter int CDF_SEGMENTS   = 256,
    parameter int PROB_FRAC_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  gbtb_pkg::gbtb_cmd_t cmd,
    output gbtb_pkg::gbtb_sts_t sts,
    input  logic signed [31:0]  s_mean_low,
    input  logic signed [31:0]  s_mean_high,
    input  logic [30:0]         s_spread,
    input  logic signed [31:0]  s_interval_low,
    input  logic signed [31:0]  s_interval_high,
    input  logic                s_last_dim,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [16:0]         m_prob_low,
    output logic [16:0]         m_prob_high
);
    import gbtb_pkg::*;

    localparam int PW  = PROB_FRAC_BITS + 1;
    localparam int SW  = $clog2(CDF_SEGMENTS + 1);
    localparam int PBW = 21 + SW;
    localparam int MW  = PW + 21;
    localparam int FINE_PER_SEG = 2 * ((2048 + CDF_SEGMENTS - 1) / CDF_SEGMENTS);
    localparam longint unsigned FINE_TOTAL = longint'(CDF_SEGMENTS) * FINE_PER_SEG;
    localparam longint unsigned FINE_SQ    = FINE_TOTAL * FINE_TOTAL;
    localparam logic [PW-1:0] ONE = PW'(1) << PROB_FRAC_BITS;

    typedef logic [PW-1:0] phi_tab_t [0:CDF_SEGMENTS];

    function automatic longint unsigned fine_pdf(input longint unsigned i);
        longint unsigned m;
        longint unsigned x26;
        m   = (2 * i >= FINE_TOTAL) ? 2 * i - FINE_TOTAL : FINE_TOTAL - 2 * i;
        x26 = (((m * m) << 31) + FINE_SQ / 2) / FINE_SQ;
        return exp_neg(x26);
    endfunction

    function automatic phi_tab_t build_phi();
        phi_tab_t        t;
        longint unsigned cum [0:CDF_SEGMENTS];
        longint unsigned s;
        longint unsigned w;
        longint unsigned q;
        longint unsigned r;
        cum[0] = 64'd0;
        for (int k = 0; k < CDF_SEGMENTS; k++) begin
            s = 64'd0;
            for (int j = 0; j <= FINE_PER_SEG; j++) begin
                w = (j == 0 || j == FINE_PER_SEG) ? 64'd1 : ((j % 2 == 1) ? 64'd4 : 64'd2);
                s = s + w * fine_pdf(longint'(k) * FINE_PER_SEG + longint'(j));
            end
            cum[k+1] = cum[k] + s;
        end
        for (int k = 0; k <= CDF_SEGMENTS; k++) begin
            q = 64'd0;
            r = cum[k];
            for (int b = 0; b < PROB_FRAC_BITS + 1; b++) begin
                r = r * 2;
                q = q * 2;
                if (r >= cum[CDF_SEGMENTS]) begin
                    r = r - cum[CDF_SEGMENTS];
                    q = q | 64'd1;
                end
            end
            t[k] = PW'((q + 64'd1) >> 1);
        end
        return t;
    endfunction

    localparam phi_tab_t PHI = build_phi();

    // item operands
    logic signed [31:0] mlo_reg, mhi_reg, a_reg, b_reg;
    logic [30:0]        s_reg;
    logic               last_reg;
    // doubled means: centre-clamped, low, high
    logic signed [32:0] mu_reg [0:2];
    logic [31:0]        d_reg;
    // divider
    logic               neg_reg, sat_reg;
    logic [35:0]        rem_reg;
    logic [18:0]        q_reg;
    // interpolator
    logic [PBW-1:0]     p_reg;
    logic [PW-1:0]      lo_reg, dd_reg;
    logic [20:0]        frac_reg;
    logic [MW-1:0]      mp_reg;
    logic [PW-1:0]      cdf_reg [0:EVAL_COUNT-1];
    // bounds and products
    logic [PW-1:0]      blo_reg, bhi_reg;
    logic [PW-1:0]      plo_reg, phi_reg;
    logic               mv_reg;
    logic [16:0]        olo_reg, ohi_reg;

    // prep
    logic signed [31:0] mlo_s, mhi_s;
    logic signed [32:0] c2, lo2, hi2, mu2;
    // eval load
    logic signed [32:0] mu_sel, x2;
    logic signed [33:0] n_val;
    logic [33:0]        n_abs;
    logic [34:0]        d8;
    logic [33:0]        d4;
    logic               ge;
    logic [35:0]        rem_sub;
    logic [19:0]        qmag;
    logic [20:0]        zoff;
    logic [SW:0]        seg_f;
    logic [SW-1:0]      idx, idx1;
    logic [MW-1:0]      rnd;
    logic [PW-1:0]      cdf_val;
    logic [PW-1:0]      mass_v [0:2];
    logic signed [PW:0] diff [0:2];
    logic [PW-1:0]      lo_min, lo_fin;
    logic [2*PW-1:0]    prod_lo, prod_hi;
    logic [PW-1:0]      plo_next, phi_next;

    always_comb begin
        mlo_s = (mhi_reg < mlo_reg) ? mhi_reg : mlo_reg;
        mhi_s = (mhi_reg < mlo_reg) ? mlo_reg : mhi_reg;
        c2    = 33'(a_reg) + 33'(b_reg);
        lo2   = {mlo_s, 1'b0};
        hi2   = {mhi_s, 1'b0};
        priority if (c2 < lo2) begin
            mu2 = lo2;
        end else if (c2 > hi2) begin
            mu2 = hi2;
        end else begin
            mu2 = c2;
        end

        mu_sel = mu_reg[cmd.sel[2:1]];
        x2     = cmd.sel[0] ? {a_reg, 1'b0} : {b_reg, 1'b0};
        n_val  = 34'(x2) - 34'(mu_sel);
        n_abs  = n_val[33] ? 34'(-n_val) : 34'(n_val);
        d8     = {d_reg, 3'b000};
        d4     = {d_reg, 2'b00};

        ge      = rem_reg >= 36'(d4);
        rem_sub = ge ? rem_reg - 36'(d4) : rem_reg;

        qmag = sat_reg ? 20'h80000 : {1'b0, q_reg};
        zoff = neg_reg ? 21'h80000 - 21'(qmag) : 21'h80000 + 21'(qmag);

        seg_f = p_reg[PBW-1:20];
        idx   = (seg_f >= (SW+1)'(CDF_SEGMENTS)) ? SW'(CDF_SEGMENTS - 1) : seg_f[SW-1:0];
        idx1  = idx + 1'b1;

        rnd     = mp_reg + MW'(1 << 19);
        cdf_val = lo_reg + PW'(rnd >> 20);

        for (int j = 0; j < 3; j++) begin
            diff[j] = $signed({1'b0, cdf_reg[2*j]}) - $signed({1'b0, cdf_reg[2*j+1]});
            priority if (diff[j] < 0) begin
                mass_v[j] = '0;
            end else if (diff[j] > $signed({1'b0, ONE})) begin
                mass_v[j] = ONE;
            end else begin
                mass_v[j] = diff[j][PW-1:0];
            end
        end
        lo_min = (mass_v[1] < mass_v[2]) ? mass_v[1] : mass_v[2];
        lo_fin = (lo_min > mass_v[0]) ? mass_v[0] : lo_min;

        prod_lo  = (2*PW)'(plo_reg) * (2*PW)'(blo_reg) + (2*PW)'(ONE >> 1);
        prod_hi  = (2*PW)'(phi_reg) * (2*PW)'(bhi_reg) + (2*PW)'(ONE >> 1);
        plo_next = PW'(prod_lo >> PROB_FRAC_BITS);
        phi_next = PW'(prod_hi >> PROB_FRAC_BITS);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mlo_reg  <= s_mean_low;
            mhi_reg  <= s_mean_high;
            s_reg    <= s_spread;
            a_reg    <= s_interval_low;
            b_reg    <= s_interval_high;
            last_reg <= s_last_dim;
        end
        if (cmd.prep) begin
            mu_reg[0] <= mu2;
            mu_reg[1] <= lo2;
            mu_reg[2] <= hi2;
            d_reg     <= (s_reg == '0) ? 32'd2 : {s_reg, 1'b0};
        end
        if (cmd.eval_load) begin
            neg_reg <= n_val[33];
            sat_reg <= 35'(n_abs) >= d8;
            rem_reg <= 36'(n_abs);
            q_reg   <= '0;
        end
        if (cmd.div_step) begin
            q_reg   <= {q_reg[17:0], ge};
            rem_reg <= rem_sub << 1;
        end
        if (cmd.cdf_a) begin
            p_reg <= PBW'(PBW'(zoff) * PBW'(CDF_SEGMENTS));
        end
        if (cmd.cdf_b) begin
            lo_reg   <= PHI[idx];
            dd_reg   <= PHI[idx1] - PHI[idx];
            frac_reg <= (seg_f >= (SW+1)'(CDF_SEGMENTS)) ? 21'h100000 : {1'b0, p_reg[19:0]};
        end
        if (cmd.cdf_c) begin
            mp_reg <= MW'(dd_reg) * MW'(frac_reg);
        end
        if (cmd.cdf_d) begin
            cdf_reg[cmd.sel] <= cdf_val;
        end
        if (cmd.mass) begin
            bhi_reg <= mass_v[0];
            blo_reg <= lo_fin;
        end
        if (cmd.prod && last_reg) begin
            olo_reg <= 17'(plo_next);
            ohi_reg <= 17'(phi_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plo_reg <= ONE;
            phi_reg <= ONE;
            mv_reg  <= 1'b0;
        end else begin
            if (cmd.prod) begin
                plo_reg <= last_reg ? ONE : plo_next;
                phi_reg <= last_reg ? ONE : phi_next;
            end
            if (cmd.prod && last_reg) begin
                mv_reg <= 1'b1;
            end else if (m_ready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    assign sts.last     = last_reg;
    assign sts.out_busy = mv_reg && !m_ready;
    assign m_valid      = mv_reg;
    assign m_prob_low   = olo_reg;
    assign m_prob_high  = ohi_reg;

endmodule

// ===== sv/gaussian_box_transition_bounds.sv =====
// Gaussian box transition bounds, top level.
// Joins gbtb_ctrl and gbtb_datapath; depends on gbtb_pkg.
//
// Input channel s_*: one word per box dimension (mean range, spread,
// target interval, last_dim flag). Result channel m_*: one word per box,
// sent after the word with last_dim set, carrying the lower and upper
// transition probability bounds in Q1.16.
// Each dimension keeps the block busy after acceptance, with s_ready low,
// so a new word is taken only once the last one is through: a prep step,
// then six CDF evaluations (each a load, a 19-step restoring divider for
// z and the interpolation: scaling, table lookup, multiply and add), then
// the bounds and the running products. The result word becomes valid once
// the last word of a box is through these steps. The divider is shared.
// A result sits in an output register; the next input word is taken while
// it waits. If a box finishes while the previous result is still unread,
// the block holds in its final cycle until m_ready frees the register.
// Reset (aresetn low, synchronous) empties the output register, returns
// the sequencer to idle and sets both running products to one.
module gaussian_box_transition_bounds #(
    parameter int CDF_SEGMENTS   = 256,
    parameter int PROB_FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_mean_low,
    input  logic signed [31:0] s_mean_high,
    input  logic [30:0]        s_spread,
    input  logic signed [31:0] s_interval_low,
    input  logic signed [31:0] s_interval_high,
    input  logic               s_last_dim,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [16:0]        m_prob_low,
    output logic [16:0]        m_prob_high
);
    import gbtb_pkg::*;

    gbtb_cmd_t cmd;
    gbtb_sts_t sts;

    gbtb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    gbtb_datapath #(
        .CDF_SEGMENTS   (CDF_SEGMENTS),
        .PROB_FRAC_BITS (PROB_FRAC_BITS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .s_mean_low      (s_mean_low),
        .s_mean_high     (s_mean_high),
        .s_spread        (s_spread),
        .s_interval_low  (s_interval_low),
        .s_interval_high (s_interval_high),
        .s_last_dim      (s_last_dim),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_prob_low      (m_prob_low),
        .m_prob_high     (m_prob_high)
    );

endmodule

// ===== bench/gaussian_box_transition_bounds_tb.sv =====
// Self-checking bench for gaussian_box_transition_bounds: drives box dimensions
// and checks the per-box lower and upper transition bound products.
// Needs only the block and its package gbtb_pkg.
module gaussian_box_transition_bounds_tb;

    localparam int SEGS      = 256;
    localparam int FRAC      = 16;
    localparam longint ONE   = 64'd1 << FRAC;
    localparam longint ZLIM  = 524288;
    localparam int FINE_SEG  = 16;
    localparam int FINE_ALL  = SEGS * FINE_SEG;
    localparam int N_RANDOM  = 1150;
    localparam int PAUSE_AT  = 700;

    typedef struct {
        logic signed [31:0] mean_low;
        logic signed [31:0] mean_high;
        logic [30:0]        spread;
        logic signed [31:0] interval_low;
        logic signed [31:0] interval_high;
        logic               last_dim;
    } dim_word_t;

    typedef struct {
        logic [16:0] lo;
        logic [16:0] hi;
    } bounds_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic signed [31:0] s_mean_low;
    logic signed [31:0] s_mean_high;
    logic [30:0]        s_spread;
    logic signed [31:0] s_interval_low;
    logic signed [31:0] s_interval_high;
    logic               s_last_dim;
    logic               m_valid;
    logic               m_ready;
    logic [16:0]        m_prob_low;
    logic [16:0]        m_prob_high;

    dim_word_t       dim_q[$];
    bounds_t         bounds_q[$];
    longint unsigned phi_tab[0:SEGS];
    longint unsigned run_lo;
    longint unsigned run_hi;
    int              errors;
    int              dims_sent;
    int              boxes_seen;
    int              burst_left;
    int              gap_left;
    int              hold_left;
    bit              hold_done;
    int              rx_cycle;

    gaussian_box_transition_bounds dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mean_low      (s_mean_low),
        .s_mean_high     (s_mean_high),
        .s_spread        (s_spread),
        .s_interval_low  (s_interval_low),
        .s_interval_high (s_interval_high),
        .s_last_dim      (s_last_dim),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_prob_low      (m_prob_low),
        .m_prob_high     (m_prob_high)
    );

    // exp(-x), x in Q6.26, result Q2.30
    function automatic longint unsigned decay_q30(input longint unsigned x26);
        longint unsigned whole;
        longint unsigned rem30;
        longint unsigned acc;
        longint unsigned term;
        whole = x26 / 64'd46516320;
        rem30 = (x26 - whole * 64'd46516320) << 4;
        acc   = 64'd1 << 30;
        term  = 64'd1 << 30;
        if (whole >= 63) begin
            return 0;
        end
        for (int k = 1; k <= 13; k++) begin
            term = ((term * rem30) >> 30) / k;
            if (k % 2 == 1) begin
                acc = acc - term;
            end else begin
                acc = acc + term;
            end
        end
        return acc >> whole;
    endfunction

    function automatic longint unsigned density_at(input longint unsigned i);
        longint unsigned span;
        longint unsigned offs;
        span = FINE_ALL;
        offs = (2 * i >= span) ? 2 * i - span : span - 2 * i;
        return decay_q30(((offs * offs << 31) + span * span / 2) / (span * span));
    endfunction

    function automatic longint unsigned scale_to_one(input longint unsigned num,
                                                     input longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = num;
        for (int b = 0; b < FRAC + 1; b++) begin
            r = r * 2;
            q = q * 2;
            if (r >= den) begin
                r = r - den;
                q = q | 1;
            end
        end
        return (q + 1) >> 1;
    endfunction

    task automatic build_phi_tab();
        longint unsigned cum[0:SEGS];
        longint unsigned seg_sum;
        longint unsigned w;
        cum[0] = 0;
        for (int k = 0; k < SEGS; k++) begin
            seg_sum = 0;
            for (int j = 0; j <= FINE_SEG; j++) begin
                w = (j == 0 || j == FINE_SEG) ? 1 : ((j % 2 == 1) ? 4 : 2);
                seg_sum += w * density_at(k * FINE_SEG + j);
            end
            cum[k + 1] = cum[k] + seg_sum;
        end
        for (int k = 0; k <= SEGS; k++) begin
            phi_tab[k] = scale_to_one(cum[k], cum[SEGS]);
        end
    endtask

    function automatic longint phi_at(input longint z);
        longint unsigned p;
        longint unsigned seg;
        longint unsigned frac;
        longint unsigned d;
        p    = longint'(z + ZLIM) * SEGS;
        seg  = p >> 20;
        frac = p & 64'hFFFFF;
        if (seg >= SEGS) begin
            seg  = SEGS - 1;
            frac = 64'd1 << 20;
        end
        d = phi_tab[seg + 1] - phi_tab[seg];
        return longint'(phi_tab[seg] + ((d * frac + (64'd1 << 19)) >> 20));
    endfunction

    function automatic longint z_score(input longint x, input longint mu2, input longint s);
        longint z;
        z = ((2 * x - mu2) * 65536) / (2 * s);
        if (z > ZLIM) z = ZLIM;
        if (z < -ZLIM) z = -ZLIM;
        return z;
    endfunction

    function automatic longint mass_in(input longint mu2, input longint s,
                                       input longint a, input longint b);
        longint m;
        m = phi_at(z_score(b, mu2, s)) - phi_at(z_score(a, mu2, s));
        if (m < 0) m = 0;
        if (m > ONE) m = ONE;
        return m;
    endfunction

    task automatic bound_dimension(input dim_word_t w);
        longint mlo;
        longint mhi;
        longint s;
        longint a;
        longint b;
        longint t;
        longint mu2;
        longint lo;
        longint hi;
        longint m1;
        longint m2;
        bounds_t r;
        mlo = w.mean_low;
        mhi = w.mean_high;
        s   = longint'({33'd0, w.spread});
        a   = w.interval_low;
        b   = w.interval_high;
        if (s == 0) s = 1;
        if (mhi < mlo) begin
            t = mlo; mlo = mhi; mhi = t;
        end
        mu2 = a + b;
        if (mu2 < 2 * mlo) mu2 = 2 * mlo;
        if (mu2 > 2 * mhi) mu2 = 2 * mhi;
        hi = mass_in(mu2, s, a, b);
        m1 = mass_in(2 * mlo, s, a, b);
        m2 = mass_in(2 * mhi, s, a, b);
        lo = (m1 < m2) ? m1 : m2;
        if (lo > hi) lo = hi;
        run_lo = (run_lo * longint'(lo) + ONE / 2) >> FRAC;
        run_hi = (run_hi * longint'(hi) + ONE / 2) >> FRAC;
        if (w.last_dim) begin
            r.lo = run_lo[16:0];
            r.hi = run_hi[16:0];
            bounds_q.insert(bounds_q.size(), r);
            run_lo = ONE;
            run_hi = ONE;
        end
    endtask

    task automatic add_dim(input logic [31:0] ml, input logic [31:0] mh, input logic [30:0] sp,
                           input logic [31:0] il, input logic [31:0] ih, input logic ld);
        dim_word_t w;
        w.mean_low      = ml;
        w.mean_high     = mh;
        w.spread        = sp;
        w.interval_low  = il;
        w.interval_high = ih;
        w.last_dim      = ld;
        dim_q.insert(dim_q.size(), w);
    endtask

    task automatic add_plausible(input logic ld);
        int c;
        int hw;
        c  = $urandom_range(0, 2097152) - 1048576;
        hw = $urandom_range(0, 262144);
        add_dim(c + $urandom_range(0, 524288) - 262144, c + $urandom_range(0, 524288) - 262144,
                $urandom_range(2048, 262144), c - hw + $urandom_range(0, 65536) - 32768,
                c + hw, ld);
    endtask

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_mean_low      = '0;
        s_mean_high     = '0;
        s_spread        = '0;
        s_interval_low  = '0;
        s_interval_high = '0;
        s_last_dim      = 1'b0;
        m_ready         = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        #12000000;
        $display("timeout at %0t", $time);
        $display("DONE: errors detected");
        $finish;
    end

    // driver
    always @(posedge aclk) begin
        dim_word_t w;
        bit        offer;
        if (!aresetn) begin
            s_valid    <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                bound_dimension('{s_mean_low, s_mean_high, s_spread, s_interval_low,
                                  s_interval_high, s_last_dim});
                dims_sent = dims_sent + 1;
            end
            offer = 1'b0;
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
            end else if (dims_sent == PAUSE_AT && bounds_q.size() != 0) begin
                offer = 1'b0;
            end else if (dim_q.size() != 0) begin
                offer = 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
            if (offer) begin
                w = dim_q.pop_front();
                s_mean_low      <= w.mean_low;
                s_mean_high     <= w.mean_high;
                s_spread        <= w.spread;
                s_interval_low  <= w.interval_low;
                s_interval_high <= w.interval_high;
                s_last_dim      <= w.last_dim;
            end
            s_valid <= offer;
        end
    end

    // monitor and receiver stalls
    always @(posedge aclk) begin
        bounds_t e;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
            rx_cycle  <= 0;
        end else begin
            rx_cycle <= rx_cycle + 1;
            if (m_valid && m_ready) begin
                boxes_seen = boxes_seen + 1;
                if (bounds_q.size() == 0) begin
                    $display("%0t: unexpected word lo=%0d hi=%0d", $time, m_prob_low, m_prob_high);
                    errors = errors + 1;
                end else begin
                    e = bounds_q.pop_front();
                    if (m_prob_low !== e.lo) begin
                        $display("%0t: prob_low expected %0d got %0d", $time, e.lo, m_prob_low);
                        errors = errors + 1;
                    end
                    if (m_prob_high !== e.hi) begin
                        $display("%0t: prob_high expected %0d got %0d", $time, e.hi, m_prob_high);
                        errors = errors + 1;
                    end
                end
            end
            if (!hold_done && boxes_seen == 30) begin
                hold_done = 1'b1;
                hold_left <= 2000;
                m_ready   <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else if ((rx_cycle / 500) % 3 == 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    initial begin
        int n;
        int dims;
        errors     = 0;
        dims_sent  = 0;
        boxes_seen = 0;
        hold_done  = 1'b0;
        run_lo     = ONE;
        run_hi     = ONE;
        build_phi_tab();

        // directed: extremes and special cases
        add_dim(32'h00010000, 32'h00010000, 31'h00010000, 32'h00000000, 32'h00020000, 1'b1);
        add_dim(32'h7FFFFFFF, 32'h80000000, 31'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 1'b1);
        add_dim(32'h00030000, 32'hFFFD0000, 31'h00008000, 32'hFFFF0000, 32'h00010000, 1'b1);
        add_dim(32'h00000000, 32'h00010000, 31'h00010000, 32'h00020000, 32'hFFFE0000, 1'b1);
        add_dim(32'h00000000, 32'h00000000, 31'd0, 32'hFFFFFFFF, 32'h00000001, 1'b1);
        add_dim(32'h00000000, 32'h00000000, 31'd1, 32'h00000001, 32'h00000002, 1'b1);
        add_dim(32'h80000000, 32'h80000000, 31'd1, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1);
        add_dim(32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 1'b1);
        add_dim(32'h00000000, 32'h00000000, 31'h00010000, 32'hFFF80000, 32'h00080000, 1'b0);
        add_dim(32'h00008000, 32'hFFFF8000, 31'h00010000, 32'hFFFF0000, 32'h00010000, 1'b0);
        add_dim(32'h00100000, 32'h00200000, 31'h00004000, 32'h00000000, 32'h00010000, 1'b1);
        add_dim(32'h00000000, 32'h00040000, 31'h00020000, 32'h00010000, 32'h00030000, 1'b0);
        add_dim(32'h00000000, 32'h00000000, 31'h00010000, 32'hFFFF0000, 32'h00010000, 1'b1);
        add_dim(32'hFFFFFFFF, 32'h00000001, 31'h7FFFFFFF, 32'h00000000, 32'h00000000, 1'b1);
        for (int i = 0; i < 6; i++) add_plausible(i == 5);

        n = 0;
        while (n < N_RANDOM) begin
            dims = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 4);
            for (int d = 0; d < dims; d++) begin
                if ($urandom_range(0, 9) < 7) begin
                    add_plausible(d == dims - 1);
                end else begin
                    add_dim($urandom, $urandom, $urandom, $urandom, $urandom,
                            ($urandom_range(0, 4) == 0) ? 1'b1 : (d == dims - 1));
                end
            end
            n += dims;
        end

        wait (aresetn);
        @(posedge aclk);
        wait (dim_q.size() == 0 && !s_valid);
        wait (bounds_q.size() == 0);
        repeat (400) @(posedge aclk);
        $display("covered %0d box dimensions, %0d boxes checked", dims_sent, boxes_seen);
        if (errors == 0 && bounds_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
